// File: rtl/wide_integer_alu_256_defines.svh
// Shared assertion macros for the wide integer ALU.
`ifndef WIDE_INTEGER_ALU_256_DEFINES_SVH
`define WIDE_INTEGER_ALU_256_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wia256 check failed");

// The consequent must hold in the cycle after the antecedent.
`define WIA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wia256 check failed");

`endif

// File: rtl/wia256_pkg.sv
package wia256_pkg;

	localparam int unsigned CNT_W = 8;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_MOD = 4'd4,
		CMD_AND = 4'd5,
		CMD_OR  = 4'd6,
		CMD_XOR = 4'd7,
		CMD_SHL = 4'd8,
		CMD_SHR = 4'd9,
		CMD_CMP = 4'd10
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_UNF  = 2'd2,
		ST_DIVZ = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ITER,
		S_FIN
	} state_e;

	typedef struct packed {
		logic [3:0]  command;
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [63:0] a_word2;
		logic [63:0] a_word3;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [63:0] b_word2;
		logic [63:0] b_word3;
		logic [8:0]  shift_amount;
	} req_t;

	typedef struct packed {
		logic [63:0] r_word0;
		logic [63:0] r_word1;
		logic [63:0] r_word2;
		logic [63:0] r_word3;
		logic        less_than;
		logic        equal;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic iterate;
	} dp_stat_t;

endpackage

// File: rtl/wia256_dp.sv
module wia256_dp (
	input  logic                clk,
	input  wia256_pkg::req_t    cmd,
	input  wia256_pkg::ctrl_t   ctrl,
	output wia256_pkg::dp_stat_t stat,
	output wia256_pkg::rsp_t    res
);

	logic [3:0]   cmd_q;
	logic [255:0] a_q, b_q, hi_q, lo_q;
	logic [8:0]   sh_q;
	wia256_pkg::rsp_t res_q, res_n;

	logic [255:0] a_in, b_in;
	logic [256:0] msum, shifted;
	logic [257:0] diff;
	logic         ge;
	logic [256:0] asum;
	logic         sub_op;
	logic [255:0] r;

	assign a_in = {cmd.a_word3, cmd.a_word2, cmd.a_word1, cmd.a_word0};
	assign b_in = {cmd.b_word3, cmd.b_word2, cmd.b_word1, cmd.b_word0};

	assign stat.iterate = (cmd.command == wia256_pkg::CMD_MUL) ||
		(((cmd.command == wia256_pkg::CMD_DIV) || (cmd.command == wia256_pkg::CMD_MOD)) &&
		(b_in != '0));

	assign msum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 257'd0);
	assign shifted = {hi_q, lo_q[255]};
	assign diff    = {1'b0, shifted} - {2'b00, b_q};
	assign ge      = !diff[257];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd.command;
			a_q   <= a_in;
			b_q   <= b_in;
			sh_q  <= cmd.shift_amount;
			hi_q  <= '0;
			lo_q  <= (cmd.command == wia256_pkg::CMD_MUL) ? b_in : a_in;
		end else if (ctrl.step) begin
			if (cmd_q == wia256_pkg::CMD_MUL) begin
				hi_q <= msum[256:1];
				lo_q <= {msum[0], lo_q[255:1]};
			end else begin
				hi_q <= ge ? diff[255:0] : shifted[255:0];
				lo_q <= {lo_q[254:0], ge};
			end
		end
		if (ctrl.load_out) begin
			res_q <= res_n;
		end
	end

	assign sub_op = (cmd_q != wia256_pkg::CMD_ADD);
	assign asum   = {1'b0, a_q} + {1'b0, sub_op ? ~b_q : b_q} + {256'd0, sub_op};

	always_comb begin
		r            = '0;
		res_n        = '0;
		res_n.status = wia256_pkg::ST_OK;
		case (cmd_q) inside
			wia256_pkg::CMD_ADD: begin
				r = asum[255:0];
				if (asum[256]) res_n.status = wia256_pkg::ST_OVF;
			end
			wia256_pkg::CMD_SUB: begin
				r = asum[255:0];
				if (!asum[256]) res_n.status = wia256_pkg::ST_UNF;
			end
			wia256_pkg::CMD_MUL: begin
				r = lo_q;
				if (hi_q != '0) res_n.status = wia256_pkg::ST_OVF;
			end
			wia256_pkg::CMD_DIV, wia256_pkg::CMD_MOD: begin
				if (b_q == '0) res_n.status = wia256_pkg::ST_DIVZ;
				else r = (cmd_q == wia256_pkg::CMD_DIV) ? lo_q : hi_q;
			end
			wia256_pkg::CMD_AND: r = a_q & b_q;
			wia256_pkg::CMD_OR:  r = a_q | b_q;
			wia256_pkg::CMD_XOR: r = a_q ^ b_q;
			wia256_pkg::CMD_SHL: r = sh_q[8] ? '0 : (a_q << sh_q[7:0]);
			wia256_pkg::CMD_SHR: r = sh_q[8] ? '0 : (a_q >> sh_q[7:0]);
			wia256_pkg::CMD_CMP: begin
				res_n.less_than = !asum[256];
				res_n.equal     = (a_q == b_q);
			end
			default: r = '0;
		endcase
		res_n.r_word0 = r[63:0];
		res_n.r_word1 = r[127:64];
		res_n.r_word2 = r[191:128];
		res_n.r_word3 = r[255:192];
	end

	assign res = res_q;

endmodule

// File: rtl/wia256_ctrl.sv
module wia256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  wia256_pkg::dp_stat_t stat,
	output wia256_pkg::ctrl_t    ctrl
);

	wia256_pkg::state_e state_q, state_n;
	logic [wia256_pkg::CNT_W-1:0] cnt_q;
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wia256_pkg::S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.load) cnt_q <= '0;
			else if (ctrl.step) cnt_q <= cnt_q + 1'b1;
			if (ctrl.load_out) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n   = state_q;
		ctrl      = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			wia256_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctrl.load = 1'b1;
					state_n   = stat.iterate ? wia256_pkg::S_ITER : wia256_pkg::S_FIN;
				end
			end
			wia256_pkg::S_ITER: begin
				ctrl.step = 1'b1;
				if (cnt_q == '1) state_n = wia256_pkg::S_FIN;
			end
			wia256_pkg::S_FIN: begin
				if (!res_valid_q || !res_stall) begin
					ctrl.load_out = 1'b1;
					state_n       = wia256_pkg::S_IDLE;
				end
			end
			default: state_n = wia256_pkg::S_IDLE;
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// File: rtl/wide_integer_alu_256.sv
// 256-bit unsigned integer ALU.
// Requests arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and one
// result per request leaves on the res channel (res_valid, res_stall, res).
// A request is taken when valid is high and stall is low at a clock edge.
// Add, subtract, logic operations, shifts and compare go straight to the
// final state, which writes the output register and raises res_valid.
// Multiply runs a shift-and-add loop and divide and remainder a restoring
// divider, each one bit per cycle, and then go to the final state;
// a division by zero skips the loop.
// One request is in flight at a time; the next is taken only once the
// controller is back in its idle state after the result is written.
// The result sits in an output register. While the receiver stalls it holds
// still, and a further request may already be taken and worked on; it
// waits in its final state until the output register is free.
// Reset clears the controller and leaves the result channel empty.
module wide_integer_alu_256 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  wia256_pkg::req_t cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output wia256_pkg::rsp_t res
);

	wia256_pkg::ctrl_t    ctrl;
	wia256_pkg::dp_stat_t stat;

	wia256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	wia256_dp u_dp (
		.clk  (clk),
		.cmd  (cmd),
		.ctrl (ctrl),
		.stat (stat),
		.res  (res)
	);

endmodule

// File: rtl/wia256_checker.sv
`include "wide_integer_alu_256_defines.svh"

module wia256_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_stall,
	input wia256_pkg::req_t cmd,
	input logic             res_valid,
	input logic             res_stall,
	input wia256_pkg::rsp_t res
);

	`WIA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`WIA_ASSERT_NEXT(a_busy_after_take, cmd_valid && !cmd_stall, cmd_stall)
	`WIA_ASSERT_SAME(a_flags_exclusive, res_valid, !(res.less_than && res.equal))
	`WIA_ASSERT_SAME(a_divz_zero, res_valid && (res.status == wia256_pkg::ST_DIVZ),
		(res.r_word0 == '0) && (res.r_word1 == '0) && (res.r_word2 == '0) &&
		(res.r_word3 == '0))

endmodule

bind wide_integer_alu_256 wia256_checker u_wia256_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
